// ===== design/ogtr_pkg.sv =====
// Shared types, widths and constants of the occupancy grid tile resampler.
`timescale 1ns / 1ps

package ogtr_pkg;

  localparam int DEF_GRID_CAPACITY = 65536;
  localparam int DEF_MAX_TILE_SIDE = 1024;

  localparam int CFG_W  = 11;
  localparam int PIX_W  = 10;
  localparam int CELL_W = 8;
  localparam int COL_W  = 8;
  localparam int KIND_W = 2;
  localparam int CIDX_W = 2;
  localparam int Q_W    = CFG_W;
  localparam int PROD_W = PIX_W + CFG_W;
  localparam int ROW_W  = 2 * CFG_W;
  localparam int IDX_W  = ROW_W + 1;
  localparam int CNT_W  = $clog2(Q_W);

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RENDER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TILE_SIZE   = 2'd2;

  localparam logic [CFG_W-1:0] MIN_TILE      = 11'd32;
  localparam logic [CFG_W-1:0] DEF_TILE      = 11'd256;
  localparam logic [COL_W-1:0] UNKNOWN_GREY  = 8'd127;
  localparam logic [COL_W-1:0] UNKNOWN_ALPHA = 8'd220;
  localparam logic [COL_W-1:0] KNOWN_ALPHA   = 8'd255;
  localparam logic [COL_W-1:0] FULL_WHITE    = 8'd255;
  localparam logic [CELL_W-1:0] OCC_MAX      = 8'd100;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [CELL_W-1:0] cell_value;
    logic [PIX_W-1:0]         pixel_x;
    logic [PIX_W-1:0]         pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [COL_W-1:0] alpha;
    logic             no_tile;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic append;
    logic clear;
    logic mul_x;
    logic div_start;
    logic mul_y;
    logic index;
    logic addr;
    logic read;
    logic load_out;
  } ogtr_cmd_t;

  typedef struct packed {
    logic none;
    logic div_done;
    logic out_free;
  } ogtr_sts_t;

endpackage

// ===== design/ogtr_div.sv =====
// Restoring divider, one quotient bit per cycle, for quotients known to fit Q_W bits.
`timescale 1ns / 1ps

module ogtr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ogtr_pkg::PROD_W-1:0]  dividend_i,
  input  logic [ogtr_pkg::CFG_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [ogtr_pkg::Q_W-1:0]     quotient_o
);

  logic [ogtr_pkg::CFG_W-1:0] rem_q, rem_d;
  logic [ogtr_pkg::Q_W-1:0]   work_q, work_d;
  logic [ogtr_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic [ogtr_pkg::CFG_W:0]   trial;
  logic                       ge;

  assign trial = {rem_q, work_q[ogtr_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    work_d = work_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = ogtr_pkg::CFG_W'(dividend_i[ogtr_pkg::PROD_W-1:ogtr_pkg::Q_W]);
      work_d = dividend_i[ogtr_pkg::Q_W-1:0];
      cnt_d  = ogtr_pkg::CNT_W'(ogtr_pkg::Q_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? ogtr_pkg::CFG_W'(trial - {1'b0, divisor_i})
                  : trial[ogtr_pkg::CFG_W-1:0];
      work_d = {work_q[ogtr_pkg::Q_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = work_q;

endmodule

// ===== design/ogtr_datapath.sv =====
// Datapath: configuration, cell memory, scaling, addressing, shading and output register.
`timescale 1ns / 1ps

module ogtr_datapath #(
  parameter int GRID_CAPACITY = ogtr_pkg::DEF_GRID_CAPACITY,
  parameter int MAX_TILE_SIDE = ogtr_pkg::DEF_MAX_TILE_SIDE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ogtr_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [ogtr_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  ogtr_pkg::in_item_t          in_data_i,
  input  ogtr_pkg::ogtr_cmd_t         cmd_i,
  output ogtr_pkg::ogtr_sts_t         sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ogtr_pkg::out_item_t         out_data_o
);

  localparam int AW = $clog2(GRID_CAPACITY);
  localparam int CW = $clog2(GRID_CAPACITY + 1);

  logic [ogtr_pkg::CFG_W-1:0]  gw_q, gh_q, tile_q;
  logic [CW-1:0]               loaded_q;
  logic [ogtr_pkg::CELL_W-1:0] mem [GRID_CAPACITY];
  logic [ogtr_pkg::PIX_W-1:0]  px_q, py_q;
  logic [ogtr_pkg::PROD_W-1:0] prod_q;
  logic [ogtr_pkg::CFG_W-1:0]  sx_q;
  logic [ogtr_pkg::ROW_W-1:0]  rowmul_q;
  logic [ogtr_pkg::IDX_W-1:0]  idx_q;
  logic                        in_range_q, none_q, out_valid_q;
  logic [ogtr_pkg::CELL_W-1:0] rd_q;
  ogtr_pkg::out_item_t         out_q, shade;

  logic [ogtr_pkg::CFG_W-1:0]  eff_t, quot, clamp_n, sclamp, row;
  logic                        none_c, render_cmd, div_done;
  logic [ogtr_pkg::CELL_W-1:0] occ;

  always_comb begin
    if (tile_q < ogtr_pkg::MIN_TILE) begin
      eff_t = ogtr_pkg::MIN_TILE;
    end else if (32'(tile_q) > 32'(MAX_TILE_SIDE)) begin
      eff_t = ogtr_pkg::CFG_W'(MAX_TILE_SIDE);
    end else begin
      eff_t = tile_q;
    end
  end

  assign none_c = (gw_q == '0) || (gh_q == '0) || (loaded_q == '0) ||
                  ({1'b0, px_q} >= eff_t) || ({1'b0, py_q} >= eff_t);

  ogtr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (eff_t),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign clamp_n = cmd_i.mul_y ? (gw_q - 1'b1) : (gh_q - 1'b1);
  assign sclamp  = (quot > clamp_n) ? clamp_n : quot;
  assign row     = gh_q - 1'b1 - sclamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q   <= '0;
      gh_q   <= '0;
      tile_q <= ogtr_pkg::DEF_TILE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ogtr_pkg::CFG_GRID_WIDTH:  gw_q   <= cfg_wdata_i;
        ogtr_pkg::CFG_GRID_HEIGHT: gh_q   <= cfg_wdata_i;
        ogtr_pkg::CFG_TILE_SIZE:   tile_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else if (cmd_i.clear) begin
      loaded_q <= '0;
    end else if (cmd_i.append && (loaded_q < CW'(GRID_CAPACITY))) begin
      loaded_q <= loaded_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (loaded_q < CW'(GRID_CAPACITY))) begin
      mem[loaded_q[AW-1:0]] <= in_data_i.cell_value;
    end
    if (cmd_i.read) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      px_q <= in_data_i.pixel_x;
      py_q <= in_data_i.pixel_y;
    end
    if (cmd_i.mul_x) begin
      prod_q <= ogtr_pkg::PROD_W'(px_q) * ogtr_pkg::PROD_W'(gw_q);
      none_q <= none_c;
    end
    if (cmd_i.mul_y) begin
      prod_q <= ogtr_pkg::PROD_W'(py_q) * ogtr_pkg::PROD_W'(gh_q);
      sx_q   <= sclamp;
    end
    if (cmd_i.index) begin
      rowmul_q <= ogtr_pkg::ROW_W'(row) * ogtr_pkg::ROW_W'(gw_q);
    end
    if (cmd_i.addr) begin
      idx_q <= ogtr_pkg::IDX_W'(rowmul_q) + ogtr_pkg::IDX_W'(sx_q);
    end
    if (cmd_i.read) begin
      in_range_q <= 32'(idx_q) < 32'(loaded_q);
    end
  end

  assign occ = (rd_q > ogtr_pkg::OCC_MAX) ? ogtr_pkg::OCC_MAX : rd_q;

  always_comb begin
    shade = '0;
    if (none_q) begin
      shade.no_tile = 1'b1;
    end else if (in_range_q) begin
      if (rd_q[ogtr_pkg::CELL_W-1]) begin
        shade.red   = ogtr_pkg::UNKNOWN_GREY;
        shade.green = ogtr_pkg::UNKNOWN_GREY;
        shade.blue  = ogtr_pkg::UNKNOWN_GREY;
        shade.alpha = ogtr_pkg::UNKNOWN_ALPHA;
      end else begin
        shade.red   = ogtr_pkg::FULL_WHITE - {occ[ogtr_pkg::COL_W-2:0], 1'b0};
        shade.green = shade.red;
        shade.blue  = shade.red;
        shade.alpha = ogtr_pkg::KNOWN_ALPHA;
      end
    end
  end

  assign render_cmd = cmd_i.load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (render_cmd) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_cmd) begin
      out_q <= shade;
    end
  end

  assign sts_o.none     = none_c;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== design/ogtr_ctrl.sv =====
// Controller state machine that sequences appends, clears and pixel renders.
`timescale 1ns / 1ps

module ogtr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [ogtr_pkg::KIND_W-1:0] kind_i,
  output logic                        in_stall_o,
  input  ogtr_pkg::ogtr_sts_t         sts_i,
  output ogtr_pkg::ogtr_cmd_t         cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MULX  = 11'b00000000010,
    S_STX   = 11'b00000000100,
    S_DIVX  = 11'b00000001000,
    S_MULY  = 11'b00000010000,
    S_STY   = 11'b00000100000,
    S_DIVY  = 11'b00001000000,
    S_INDEX = 11'b00010000000,
    S_ADDR  = 11'b00100000000,
    S_READ  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            ogtr_pkg::KIND_APPEND: cmd_o.append = 1'b1;
            ogtr_pkg::KIND_CLEAR:  cmd_o.clear  = 1'b1;
            ogtr_pkg::KIND_RENDER: begin
              cmd_o.latch = 1'b1;
              state_d     = S_MULX;
            end
            default: ;
          endcase
        end
      end
      S_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d     = sts_i.none ? S_DONE : S_STX;
      end
      S_STX: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVX;
      end
      S_DIVX: begin
        if (sts_i.div_done) begin
          state_d = S_MULY;
        end
      end
      S_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d     = S_STY;
      end
      S_STY: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVY;
      end
      S_DIVY: begin
        if (sts_i.div_done) begin
          state_d = S_INDEX;
        end
      end
      S_INDEX: begin
        cmd_o.index = 1'b1;
        state_d     = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== design/occupancy_grid_tile_resampler_top.sv =====
// Top level of the occupancy grid tile resampler.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    ogtr_pkg::in_item_t
//   out       output     out_valid_o / out_stall_i  ogtr_pkg::out_item_t
//   cfg       input      cfg_we_i (no wait)         cfg_index_i, cfg_wdata_i
//
// Appends and clears leave the input free. A render holds in_stall_o over two
// 11-step runs of the shared bit-serial divider, skipped for no_tile. Reset
// clears the fill count, geometry and control state and sets the default tile
// size; the cell memory holds whatever it held. A result waits in the output
// register while out_stall_i is high, and the next item is still taken.
`timescale 1ns / 1ps

module occupancy_grid_tile_resampler_top #(
  parameter int GRID_CAPACITY = ogtr_pkg::DEF_GRID_CAPACITY,
  parameter int MAX_TILE_SIDE = ogtr_pkg::DEF_MAX_TILE_SIDE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ogtr_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [ogtr_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ogtr_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ogtr_pkg::out_item_t         out_data_o
);

  ogtr_pkg::ogtr_cmd_t cmd;
  ogtr_pkg::ogtr_sts_t sts;

  ogtr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ogtr_datapath #(
    .GRID_CAPACITY (GRID_CAPACITY),
    .MAX_TILE_SIDE (MAX_TILE_SIDE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.kind == ogtr_pkg::KIND_RENDER)
    |=> in_stall_o)
    else $error("render transfer did not occupy the controller");

  a_store_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    ((in_data_i.kind == ogtr_pkg::KIND_APPEND) || (in_data_i.kind == ogtr_pkg::KIND_CLEAR))
    |=> !in_stall_o)
    else $error("append or clear held the input side");

  a_result_from_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> in_stall_o)
    else $error("result loaded with no render in progress");

  a_no_tile_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_tile |->
    (out_data_o.red == '0) && (out_data_o.green == '0) &&
    (out_data_o.blue == '0) && (out_data_o.alpha == '0))
    else $error("no_tile result carries color");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the occupancy grid tile resampler with randomized flow control.
`timescale 1ns / 1ps

module tb_top;

  localparam int CAPACITY = ogtr_pkg::DEF_GRID_CAPACITY;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER = 300;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [ogtr_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [ogtr_pkg::CIDX_W-1:0] cfg_index_i = '0;
  logic [ogtr_pkg::CFG_W-1:0]  cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  ogtr_pkg::in_item_t          in_data_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  ogtr_pkg::out_item_t         out_data_o;

  ogtr_pkg::in_item_t          grid_ops[$];
  ogtr_pkg::out_item_t         pending_pixels[$];
  logic [ogtr_pkg::CELL_W-1:0] cell_mem [CAPACITY];
  int unsigned       cells_held = 0;
  int unsigned       width_reg = 0;
  int unsigned       height_reg = 0;
  int unsigned       tile_reg = 32'(ogtr_pkg::DEF_TILE);
  int unsigned       error_count = 0;
  int unsigned       pixels_seen = 0;
  int unsigned       cycle_count = 0;
  int unsigned       random_items = 0;
  int unsigned       gap_left = 0;
  int unsigned       burst_left = 0;
  int unsigned       hold_left = 0;
  bit                held_off = 1'b0;
  int unsigned       mode_left = 0;
  stall_mode_e       stall_mode = STALL_NONE;

  occupancy_grid_tile_resampler_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned effective_tile(int unsigned t);
    if (t < ogtr_pkg::MIN_TILE) return 32'(ogtr_pkg::MIN_TILE);
    if (t > ogtr_pkg::DEF_MAX_TILE_SIDE) return ogtr_pkg::DEF_MAX_TILE_SIDE;
    return t;
  endfunction

  function automatic ogtr_pkg::out_item_t shade_cell(logic signed [ogtr_pkg::CELL_W-1:0] c);
    ogtr_pkg::out_item_t px;
    int occ;
    px = '0;
    occ = int'(c);
    if (occ < 0) begin
      px.red = ogtr_pkg::UNKNOWN_GREY;
      px.green = ogtr_pkg::UNKNOWN_GREY;
      px.blue = ogtr_pkg::UNKNOWN_GREY;
      px.alpha = ogtr_pkg::UNKNOWN_ALPHA;
    end else begin
      if (occ > int'(ogtr_pkg::OCC_MAX)) occ = int'(ogtr_pkg::OCC_MAX);
      px.red = ogtr_pkg::COL_W'(int'(ogtr_pkg::FULL_WHITE) - 2 * occ);
      px.green = px.red;
      px.blue = px.red;
      px.alpha = ogtr_pkg::KNOWN_ALPHA;
    end
    return px;
  endfunction

  function automatic void render_item(ogtr_pkg::in_item_t it);
    ogtr_pkg::out_item_t px;
    int unsigned t;
    int unsigned sx;
    int unsigned sy;
    int unsigned src;
    px = '0;
    case (it.kind)
      ogtr_pkg::KIND_APPEND: begin
        if (cells_held < CAPACITY) begin
          cell_mem[cells_held] = it.cell_value;
          cells_held++;
        end
      end
      ogtr_pkg::KIND_CLEAR: cells_held = 0;
      ogtr_pkg::KIND_RENDER: begin
        t = effective_tile(tile_reg);
        if (width_reg == 0 || height_reg == 0 || cells_held == 0 ||
            it.pixel_x >= t || it.pixel_y >= t) begin
          px.no_tile = 1'b1;
        end else begin
          sx = it.pixel_x * width_reg / t;
          if (sx > width_reg - 1) sx = width_reg - 1;
          sy = it.pixel_y * height_reg / t;
          if (sy > height_reg - 1) sy = height_reg - 1;
          src = (height_reg - 1 - sy) * width_reg + sx;
          if (src < cells_held) px = shade_cell(cell_mem[src]);
        end
        pending_pixels.insert(pending_pixels.size(), px);
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [ogtr_pkg::COL_W-1:0] want,
                                        logic [ogtr_pkg::COL_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_pixel(ogtr_pkg::out_item_t got);
    ogtr_pkg::out_item_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t ns: unexpected pixel, expected none, got %p", $time, got);
      error_count++;
    end else begin
      want = pending_pixels[0];
      pending_pixels.delete(0);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("no_tile", ogtr_pkg::COL_W'(want.no_tile),
                    ogtr_pkg::COL_W'(got.no_tile));
    end
  endfunction

  function automatic void push_op(logic [ogtr_pkg::KIND_W-1:0] kind, int unsigned cell_bits,
                                  int unsigned x, int unsigned y);
    ogtr_pkg::in_item_t it;
    it.kind = kind;
    it.cell_value = ogtr_pkg::CELL_W'(cell_bits);
    it.pixel_x = ogtr_pkg::PIX_W'(x);
    it.pixel_y = ogtr_pkg::PIX_W'(y);
    grid_ops.insert(grid_ops.size(), it);
  endfunction

  function automatic int unsigned random_cell();
    case ($urandom_range(0, 3))
      0, 1: return $urandom_range(0, 100);
      2: return $urandom_range(128, 255);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void queue_fill(int unsigned n_cells, int unsigned n_render);
    int unsigned eff;
    eff = effective_tile(tile_reg);
    push_op(ogtr_pkg::KIND_CLEAR, $urandom, $urandom, $urandom);
    repeat (n_cells) push_op(ogtr_pkg::KIND_APPEND, random_cell(), $urandom, $urandom);
    repeat (n_render) begin
      case ($urandom_range(0, 19))
        0: push_op(KIND_NONE, $urandom, $urandom, $urandom);
        1: push_op(ogtr_pkg::KIND_APPEND, random_cell(), $urandom, $urandom);
        2, 3: push_op(ogtr_pkg::KIND_RENDER, $urandom, $urandom, $urandom);
        default: push_op(ogtr_pkg::KIND_RENDER, $urandom, $urandom_range(0, eff - 1),
                         $urandom_range(0, eff - 1));
      endcase
    end
  endfunction

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned t);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= ogtr_pkg::CFG_GRID_WIDTH;
    cfg_wdata_i <= ogtr_pkg::CFG_W'(w);
    width_reg = 32'(ogtr_pkg::CFG_W'(w));
    @(posedge clk_i);
    cfg_index_i <= ogtr_pkg::CFG_GRID_HEIGHT;
    cfg_wdata_i <= ogtr_pkg::CFG_W'(h);
    height_reg = 32'(ogtr_pkg::CFG_W'(h));
    @(posedge clk_i);
    cfg_index_i <= ogtr_pkg::CFG_TILE_SIZE;
    cfg_wdata_i <= ogtr_pkg::CFG_W'(t);
    tile_reg = 32'(ogtr_pkg::CFG_W'(t));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (grid_ops.size() != 0 || in_valid_i || pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned t,
                           int unsigned n_cells, int unsigned n_render);
    set_geometry(w, h, t);
    queue_fill(n_cells, n_render);
    random_items += n_cells + n_render;
    drain();
  endtask

  // advance on a transfer or while idle, hold while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) render_item(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 || grid_ops.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_data_i <= grid_ops[0];
          grid_ops.delete(0);
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_pixel(out_data_o);
        pixels_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!held_off && pixels_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE: out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HALF: out_stall_i <= ($urandom_range(0, 1) == 1);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned t;
    int unsigned n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_op(ogtr_pkg::KIND_RENDER, $urandom, 5, 5);
    drain();

    set_geometry(4, 3, 32);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 0, 0);
    push_op(ogtr_pkg::KIND_APPEND, 'h80, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 'hff, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 0, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 1, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 50, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 100, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 101, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 127, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 7, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 99, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 'hce, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_APPEND, 64, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 0, 0);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 31, 31);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 8, 31);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 16, 16);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 32, 0);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 0, 1023);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 1023, 5);
    push_op(KIND_NONE, $urandom, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_CLEAR, $urandom, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 0, 0);
    push_op(ogtr_pkg::KIND_APPEND, 5, $urandom, $urandom);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 31, 31);
    push_op(ogtr_pkg::KIND_RENDER, $urandom, 0, 31);
    drain();

    run_phase(0, 5, 64, 8, 12);
    run_phase(5, 0, 64, 8, 12);
    run_phase(1, 1, 32, 1, 30);
    run_phase(2047, 1, 2047, 300, 40);
    run_phase(1, 1024, 0, 200, 40);
    run_phase(2047, 2047, 1024, 100, 30);
    while (random_items < RANDOM_ITEMS) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: t = $urandom_range(0, 2047);
        1: t = $urandom_range(32, 64);
        default: t = $urandom_range(32, 1024);
      endcase
      n = w * h;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, w * h);
      run_phase(w, h, t, n, $urandom_range(40, 80));
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ogtr_pkg.sv
design/ogtr_div.sv
design/ogtr_datapath.sv
design/ogtr_ctrl.sv
design/occupancy_grid_tile_resampler_top.sv
test/tb_top.sv
